@@ sv/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants and command codes of the text console scrollback block.
// ----------------------------------------------------------------------------
package tcs_pkg;

   localparam int TCS_COLUMNS       = 80;
   localparam int TCS_ROWS          = 25;
   localparam int TCS_HISTORY_LINES = 30;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [2:0] {
      CMD_PUT_CHAR    = 3'd0,
      CMD_SET_CURSOR  = 3'd1,
      CMD_SCROLL_VIEW = 3'd2,
      CMD_SET_FOLLOW  = 3'd3,
      CMD_READ_CELL   = 3'd4,
      CMD_HOME_CURSOR = 3'd5
   } tcs_cmd_type;

endpackage

@@ sv/text_console_scrollback.sv @@
// ----------------------------------------------------------------------------
// text_console_scrollback
// Text console over a ring buffer of history lines held in one memory.
// ----------------------------------------------------------------------------
// Flow: a stored character or a cell read goes from ST_ADDR to ST_REDUCE, which
// subtracts the buffer size from the address sum until it is below that size,
// then to ST_RESP; every other command goes from ST_ADDR to ST_RESP. One item at
// a time: the next item is taken once the result is posted, and posting waits
// while an earlier result is held and not yet taken. Reset: synchronous; a
// clearing pass writes zero to every history entry before the first item.
// ----------------------------------------------------------------------------
module text_console_scrollback #(
   parameter int COLUMNS       = tcs_pkg::TCS_COLUMNS,
   parameter int ROWS          = tcs_pkg::TCS_ROWS,
   parameter int HISTORY_LINES = tcs_pkg::TCS_HISTORY_LINES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_pos_col,
   input  logic [4:0]  req_pos_row,
   input  logic [5:0]  req_line_offset,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_cell_char,
   output logic        rsp_cell_filled,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic        rsp_following
);
   import tcs_pkg::*;

   localparam int BUF_CELLS = HISTORY_LINES * COLUMNS;
   localparam int AW        = $clog2(BUF_CELLS);
   localparam int SW        = $clog2(BUF_CELLS + 32 * COLUMNS + 2048);
   localparam int LW        = $clog2(HISTORY_LINES);
   localparam int LRW       = $clog2(2 * HISTORY_LINES + 32);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ADDR   = 5'b00100,
      ST_REDUCE = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   wb_ff, wb_in;
   logic [AW-1:0]   vb_ff, vb_in;
   logic            follow_ff, follow_in;
   logic [6:0]      col_ff, col_in;
   logic [4:0]      row_ff, row_in;
   logic [7:0]      char_ff, char_in;
   logic [10:0]     cidx_ff, cidx_in;
   logic [6:0]      ax_ff, ax_in;
   logic [4:0]      ay_ff, ay_in;
   logic [LW-1:0]   lines_ff, lines_in;
   logic            do_write_ff, do_write_in;
   logic            do_read_ff, do_read_in;
   logic            do_scroll_ff, do_scroll_in;
   logic [SW-1:0]   red_ff, red_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_filled_ff, rsp_filled_in;
   logic [6:0]      rsp_col_ff, rsp_col_in;
   logic [4:0]      rsp_row_ff, rsp_row_in;
   logic            rsp_follow_ff, rsp_follow_in;

   logic [7:0]      hist_mem [BUF_CELLS];
   logic [7:0]      mem_rd_ff;
   logic            mem_we;
   logic            mem_re;
   logic [AW-1:0]   mem_addr;
   logic [7:0]      mem_wdata;

   logic            row_wrap;
   logic [6:0]      next_col;
   logic [AW:0]     wb_adv_sum;
   logic [AW-1:0]   wb_adv;
   logic [LRW-1:0]  lines_red;
   logic            scroll_skip;
   logic [SW-1:0]   sum_put;
   logic [SW-1:0]   sum_rd;
   logic [AW:0]     vb_sum;
   logic [AW-1:0]   vb_scrolled;
   logic            red_done;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_char   = rsp_char_ff;
   assign rsp_cell_filled = rsp_filled_ff;
   assign rsp_cursor_col  = rsp_col_ff;
   assign rsp_cursor_row  = rsp_row_ff;
   assign rsp_following   = rsp_follow_ff;

   assign row_wrap   = {27'd0, row_ff} >= 32'(ROWS);
   assign next_col   = col_ff + 7'd1;
   assign wb_adv_sum = (AW+1)'(wb_ff) + (AW+1)'(COLUMNS);
   assign wb_adv     = (wb_adv_sum >= (AW+1)'(BUF_CELLS)) ?
                       AW'(wb_adv_sum - (AW+1)'(BUF_CELLS)) : AW'(wb_adv_sum);

   // reduce the signed offset to 0 .. HISTORY_LINES-1
   always_comb begin : lines_calc
      logic [LRW-1:0] v;
      v = LRW'(2 * HISTORY_LINES) + {{(LRW-6){req_line_offset[5]}}, req_line_offset};
      for (int i = 0; i < 3; i++) begin
         if (v >= LRW'(HISTORY_LINES)) begin
            v = v - LRW'(HISTORY_LINES);
         end
      end
      lines_red = v;
   end

   assign scroll_skip = follow_ff && !req_line_offset[5] && (req_line_offset != 6'd0)
                        && (vb_ff == wb_ff);

   assign sum_put     = SW'(wb_ff) + SW'(ay_ff) * SW'(COLUMNS) + SW'(ax_ff);
   assign sum_rd      = SW'(vb_ff) + SW'(cidx_ff);
   assign vb_sum      = (AW+1)'(vb_ff) + (AW+1)'(lines_ff) * (AW+1)'(COLUMNS);
   assign vb_scrolled = (vb_sum >= (AW+1)'(BUF_CELLS)) ?
                        AW'(vb_sum - (AW+1)'(BUF_CELLS)) : AW'(vb_sum);
   assign red_done    = red_ff < SW'(BUF_CELLS);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      wb_in         = wb_ff;
      vb_in         = vb_ff;
      follow_in     = follow_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      char_in       = char_ff;
      cidx_in       = cidx_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      lines_in      = lines_ff;
      do_write_in   = do_write_ff;
      do_read_in    = do_read_ff;
      do_scroll_in  = do_scroll_ff;
      red_in        = red_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_filled_in = rsp_filled_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_follow_in = rsp_follow_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = red_ff[AW-1:0];
      mem_wdata     = char_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'd0;
            if (clr_ff == AW'(BUF_CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in     = ST_ADDR;
               char_in      = req_char_code;
               cidx_in      = req_cell_index;
               do_write_in  = 1'b0;
               do_read_in   = 1'b0;
               do_scroll_in = 1'b0;
               case (req_cmd)
                  CMD_PUT_CHAR: begin
                     if (req_char_code == NEWLINE_CODE) begin
                        col_in = 7'd0;
                        if (row_wrap) begin
                           wb_in = wb_adv;
                        end else begin
                           row_in = row_ff + 5'd1;
                        end
                     end else begin
                        do_write_in = 1'b1;
                        if (row_wrap) begin
                           wb_in = wb_adv;
                           ax_in = 7'd0;
                           ay_in = row_ff - 5'd1;
                        end else begin
                           ax_in = col_ff;
                           ay_in = row_ff;
                        end
                        if ({25'd0, next_col} >= 32'(COLUMNS)) begin
                           col_in = 7'd0;
                           row_in = (row_wrap ? row_ff - 5'd1 : row_ff) + 5'd1;
                        end else begin
                           col_in = next_col;
                           row_in = row_wrap ? row_ff - 5'd1 : row_ff;
                        end
                     end
                  end
                  CMD_SET_CURSOR: begin
                     col_in = req_pos_col;
                     row_in = req_pos_row;
                  end
                  CMD_SCROLL_VIEW: begin
                     if (!scroll_skip) begin
                        follow_in    = 1'b0;
                        do_scroll_in = 1'b1;
                        lines_in     = LW'(lines_red);
                     end
                  end
                  CMD_SET_FOLLOW: begin
                     follow_in = 1'b1;
                  end
                  CMD_READ_CELL: begin
                     do_read_in = 1'b1;
                     if (follow_ff) begin
                        vb_in = wb_ff;
                     end
                  end
                  CMD_HOME_CURSOR: begin
                     col_in = 7'd0;
                     row_in = 5'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADDR: begin
            red_in = do_write_ff ? sum_put : sum_rd;
            if (do_scroll_ff) begin
               vb_in = vb_scrolled;
            end
            state_in = (do_write_ff || do_read_ff) ? ST_REDUCE : ST_RESP;
         end
         ST_REDUCE: begin
            if (red_done) begin
               mem_we   = do_write_ff;
               mem_re   = do_read_ff;
               state_in = ST_RESP;
            end else begin
               red_in = red_ff - SW'(BUF_CELLS);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = do_read_ff ? mem_rd_ff : 8'd0;
               rsp_filled_in = do_read_ff && (mem_rd_ff != 8'd0);
               rsp_col_in    = col_ff;
               rsp_row_in    = row_ff;
               rsp_follow_in = follow_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wb_ff        <= '0;
         vb_ff        <= '0;
         follow_ff    <= 1'b1;
         col_ff       <= 7'd0;
         row_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wb_ff        <= wb_in;
         vb_ff        <= vb_in;
         follow_ff    <= follow_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      cidx_ff       <= cidx_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      lines_ff      <= lines_in;
      do_write_ff   <= do_write_in;
      do_read_ff    <= do_read_in;
      do_scroll_ff  <= do_scroll_in;
      red_ff        <= red_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_filled_ff <= rsp_filled_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_follow_ff <= rsp_follow_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= hist_mem[mem_addr];
      end
   end

   a_bases_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, wb_ff} < (AW+1)'(BUF_CELLS)) && ({1'b0, vb_ff} < (AW+1)'(BUF_CELLS)))
      else $error("ring base out of range");

   a_access_reduced: assert property (@(posedge clock) disable iff (reset)
      (mem_re || (mem_we && state_ff != ST_CLEAR)) |-> red_done)
      else $error("memory accessed with unreduced address");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("read and write in one cycle");

   a_accept_to_addr: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_ADDR))
      else $error("accepted item not processed");

endmodule
